### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Widths, fixed-point constants and stage transfer types of the sine block.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int ANGLE_W              = 32;
   localparam int OUT_W                = 18;
   localparam int ANGLE_FRAC_BITS_DEF  = 16;
   localparam int OUT_FRAC_BITS_DEF    = 16;

   localparam int R_W                  = 36;
   localparam int M30_W                = 31;
   localparam int X2_W                 = 32;
   localparam int NM_W                 = 28;
   localparam int Q_W                  = 30;
   localparam int Y_W                  = 31;
   localparam int PROD_SH              = 30;
   localparam int MAG_SAT_MAX          = 131071;

   localparam int PIPE_LAT             = 9;

   localparam logic [30:0] INV_PI_Q32     = 31'd1367130551;
   localparam logic [33:0] PI_Q32         = 34'd13493037705;
   localparam logic [22:0] COEF_A_Q30     = 23'd7894653;
   localparam logic [27:0] COEF_B_MAG_Q30 = 28'd177477835;
   localparam logic [29:0] COEF_C_Q30     = 30'd1073411097;

   typedef struct packed {
      logic             valid;
      logic             negate;
      logic [M30_W-1:0] m30;
   } red_out_type;

   typedef struct packed {
      logic           valid;
      logic           negate;
      logic [Y_W-1:0] y;
   } poly_out_type;

endpackage

### src/sine_poly_approx.sv
// ----------------------------------------------------------------------------
// sine_poly_approx
// Fixed-point sine: reduction by pi, odd quintic polynomial, sign fix-up.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_angle (signed, ANGLE_FRAC_BITS fraction bits) and
//   raise start. A transfer happens at each rising edge with start high and
//   busy low. busy is low whenever reset is low, so one angle may enter on
//   every cycle.
//   Response: rsp_valid strobes for one cycle with rsp_sine_value (signed,
//   OUT_FRAC_BITS fraction bits, magnitude at most 1.0). Results come out in
//   request order.
//   Throughput: one item per cycle. Latency is set by the nine register
//   stages: magnitude, k multiply, k*pi multiply, |r|, and one stage per
//   polynomial product (four) and the output rounding stage.
//   Reset (synchronous) clears all stage valid bits; items in flight are
//   dropped and busy is high while reset is held.
//   The receiver has no stall; every strobed result must be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_poly_approx #(
   parameter int ANGLE_FRAC_BITS = spa_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS   = spa_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [spa_pkg::ANGLE_W-1:0] req_angle,
   output logic                        rsp_valid,
   output logic [spa_pkg::OUT_W-1:0]   rsp_sine_value
);

   localparam int OUT_LIM = (OUT_FRAC_BITS > 16) ? spa_pkg::MAG_SAT_MAX
                                                 : (1 << OUT_FRAC_BITS);
   localparam logic signed [spa_pkg::OUT_W:0] OUT_LIM_V = (spa_pkg::OUT_W + 1)'(OUT_LIM);

   spa_pkg::red_out_type  red_out;
   spa_pkg::poly_out_type poly_out;
   logic                  req_xfer;

   assign busy     = reset;
   assign req_xfer = start & ~busy;

   spa_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_xfer),
      .in_angle(req_angle),
      .red_out (red_out)
   );

   spa_poly u_poly (
      .clock   (clock),
      .reset   (reset),
      .red_in  (red_out),
      .poly_out(poly_out)
   );

   spa_finish #(
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) u_finish (
      .clock         (clock),
      .reset         (reset),
      .poly_in       (poly_out),
      .rsp_valid     (rsp_valid),
      .rsp_sine_value(rsp_sine_value)
   );

   `ASSERT_CLK(a_req_to_rsp, req_xfer |-> ##(spa_pkg::PIPE_LAT) rsp_valid, "lost result")
   `ASSERT_CLK(a_rsp_has_req, rsp_valid |-> $past(req_xfer, spa_pkg::PIPE_LAT), "spurious result")
   `ASSERT_CLK(a_zero_in, (req_xfer && (req_angle == '0)) |-> ##(spa_pkg::PIPE_LAT) (rsp_sine_value == '0), "sine of zero not zero")
   `ASSERT_ALWAYS_CLK(a_mag_bound, rsp_valid |-> (($signed(rsp_sine_value) <= OUT_LIM_V) && ($signed(rsp_sine_value) >= -OUT_LIM_V)), "magnitude above one")

endmodule

### src/spa_reduce.sv
// ----------------------------------------------------------------------------
// spa_reduce
// Range reduction: k = round(angle/pi), r = angle - k*pi, m30 = |r| in Q.30.
// ----------------------------------------------------------------------------
module spa_reduce #(
   parameter int ANGLE_FRAC_BITS = spa_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [spa_pkg::ANGLE_W-1:0] in_angle,
   output spa_pkg::red_out_type        red_out
);

   localparam int KW = spa_pkg::ANGLE_W - ANGLE_FRAC_BITS;
   localparam int SH = spa_pkg::ANGLE_W - ANGLE_FRAC_BITS;
   localparam logic [63:0] HALF_K = 64'd1 << (ANGLE_FRAC_BITS + 31);

   // stage A: magnitude
   logic                        a_valid_ff;
   logic                        a_neg_ff;
   logic [spa_pkg::ANGLE_W-1:0] a_mag_ff;
   logic [spa_pkg::ANGLE_W-1:0] a_ang_ff;
   logic [spa_pkg::ANGLE_W-1:0] a_mag_in;

   // stage B: k
   logic                        b_valid_ff;
   logic                        b_neg_ff;
   logic [KW-1:0]               b_kmag_ff;
   logic [spa_pkg::ANGLE_W-1:0] b_ang_ff;
   logic [62:0]                 b_prod;
   logic [63:0]                 b_sum;
   logic [KW-1:0]               b_kmag_in;

   // stage C: residue
   logic                        c_valid_ff;
   logic                        c_kodd_ff;
   logic [spa_pkg::R_W-1:0]     c_r_ff;
   logic [63:0]                 c_ang_ext;
   logic [63:0]                 c_ang_sh;
   logic [KW+33:0]              c_kp;
   logic [spa_pkg::R_W-1:0]     c_r_in;

   // stage D: |r| to Q.30
   spa_pkg::red_out_type        d_out_ff;
   spa_pkg::red_out_type        d_out_in;
   logic [spa_pkg::R_W-1:0]     d_m;
   logic [spa_pkg::R_W-1:0]     d_m_rnd;

   assign a_mag_in = in_angle[spa_pkg::ANGLE_W-1] ? (32'd0 - in_angle) : in_angle;

   assign b_prod    = a_mag_ff * spa_pkg::INV_PI_Q32;
   assign b_sum     = {1'b0, b_prod} + HALF_K;
   assign b_kmag_in = b_sum[ANGLE_FRAC_BITS+32 +: KW];

   assign c_ang_ext = {{32{b_ang_ff[spa_pkg::ANGLE_W-1]}}, b_ang_ff};
   assign c_ang_sh  = c_ang_ext << SH;
   assign c_kp      = b_kmag_ff * spa_pkg::PI_Q32;
   assign c_r_in    = b_neg_ff ? (c_ang_sh[spa_pkg::R_W-1:0] + c_kp[spa_pkg::R_W-1:0])
                               : (c_ang_sh[spa_pkg::R_W-1:0] - c_kp[spa_pkg::R_W-1:0]);

   assign d_m     = c_r_ff[spa_pkg::R_W-1] ? ({spa_pkg::R_W{1'b0}} - c_r_ff) : c_r_ff;
   assign d_m_rnd = d_m + {{(spa_pkg::R_W-2){1'b0}}, 2'd2};

   always_comb begin
      d_out_in.valid  = c_valid_ff;
      d_out_in.negate = c_r_ff[spa_pkg::R_W-1] ^ c_kodd_ff;
      d_out_in.m30    = d_m_rnd[spa_pkg::M30_W+1:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_out_ff.valid <= 1'b0;
      end else begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         d_out_ff.valid <= d_out_in.valid;
      end
      a_neg_ff        <= in_angle[spa_pkg::ANGLE_W-1];
      a_mag_ff        <= a_mag_in;
      a_ang_ff        <= in_angle;
      b_neg_ff        <= a_neg_ff;
      b_kmag_ff       <= b_kmag_in;
      b_ang_ff        <= a_ang_ff;
      c_kodd_ff       <= b_kmag_ff[0];
      c_r_ff          <= c_r_in;
      d_out_ff.negate <= d_out_in.negate;
      d_out_ff.m30    <= d_out_in.m30;
   end

   assign red_out = d_out_ff;

endmodule

### src/spa_poly.sv
// ----------------------------------------------------------------------------
// spa_poly
// Odd quintic on m30: y = m*(C + x2*(B + A*x2)), one product per stage.
// ----------------------------------------------------------------------------
module spa_poly (
   input  logic                  clock,
   input  logic                  reset,
   input  spa_pkg::red_out_type  red_in,
   output spa_pkg::poly_out_type poly_out
);

   localparam logic [62:0] RND63 = 63'd1 << (spa_pkg::PROD_SH - 1);
   localparam logic [55:0] RND56 = 56'd1 << (spa_pkg::PROD_SH - 1);
   localparam logic [60:0] RND61 = 61'd1 << (spa_pkg::PROD_SH - 1);
   localparam logic [61:0] RND62 = 62'd1 << (spa_pkg::PROD_SH - 1);

   // stage E: x2 = m^2
   logic                      e_valid_ff;
   logic                      e_neg_ff;
   logic [spa_pkg::M30_W-1:0] e_m30_ff;
   logic [spa_pkg::X2_W-1:0]  e_x2_ff;
   logic [62:0]               e_full;

   // stage F: nm = -(B + A*x2)
   logic                      f_valid_ff;
   logic                      f_neg_ff;
   logic [spa_pkg::M30_W-1:0] f_m30_ff;
   logic [spa_pkg::X2_W-1:0]  f_x2_ff;
   logic [spa_pkg::NM_W-1:0]  f_nm_ff;
   logic [55:0]               f_full;
   logic [spa_pkg::NM_W-1:0]  f_nm_in;

   // stage G: q = C - nm*x2
   logic                      g_valid_ff;
   logic                      g_neg_ff;
   logic [spa_pkg::M30_W-1:0] g_m30_ff;
   logic [spa_pkg::Q_W-1:0]   g_q_ff;
   logic [60:0]               g_full;
   logic [spa_pkg::Q_W:0]     g_q_in;

   // stage H: y = q*m
   spa_pkg::poly_out_type     h_out_ff;
   logic [61:0]               h_full;

   assign e_full  = red_in.m30 * red_in.m30 + RND63;
   assign f_full  = spa_pkg::COEF_A_Q30 * e_x2_ff + RND56;
   assign f_nm_in = spa_pkg::COEF_B_MAG_Q30 - {2'b00, f_full[55:30]};
   assign g_full  = f_nm_ff * f_x2_ff + RND61;
   assign g_q_in  = {1'b0, spa_pkg::COEF_C_Q30} - g_full[60:30];
   assign h_full  = g_q_ff * g_m30_ff + RND62;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff     <= 1'b0;
         f_valid_ff     <= 1'b0;
         g_valid_ff     <= 1'b0;
         h_out_ff.valid <= 1'b0;
      end else begin
         e_valid_ff     <= red_in.valid;
         f_valid_ff     <= e_valid_ff;
         g_valid_ff     <= f_valid_ff;
         h_out_ff.valid <= g_valid_ff;
      end
      e_neg_ff        <= red_in.negate;
      e_m30_ff        <= red_in.m30;
      e_x2_ff         <= e_full[61:30];
      f_neg_ff        <= e_neg_ff;
      f_m30_ff        <= e_m30_ff;
      f_x2_ff         <= e_x2_ff;
      f_nm_ff         <= f_nm_in;
      g_neg_ff        <= f_neg_ff;
      g_m30_ff        <= f_m30_ff;
      g_q_ff          <= g_q_in[spa_pkg::Q_W-1:0];
      h_out_ff.negate <= g_neg_ff;
      h_out_ff.y      <= h_full[60:30];
   end

   assign poly_out = h_out_ff;

endmodule

### src/spa_finish.sv
// ----------------------------------------------------------------------------
// spa_finish
// Output rounding to OUT_FRAC_BITS, saturation, sign and result register.
// ----------------------------------------------------------------------------
module spa_finish #(
   parameter int OUT_FRAC_BITS = spa_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spa_pkg::poly_out_type     poly_in,
   output logic                      rsp_valid,
   output logic [spa_pkg::OUT_W-1:0] rsp_sine_value
);

   localparam int SH = spa_pkg::PROD_SH - OUT_FRAC_BITS;
   localparam logic [31:0] MAG_LIM = (OUT_FRAC_BITS > 16) ? 32'(spa_pkg::MAG_SAT_MAX)
                                                         : (32'd1 << OUT_FRAC_BITS);

   logic                      rsp_valid_ff;
   logic [spa_pkg::OUT_W-1:0] rsp_value_ff;
   logic [spa_pkg::OUT_W-1:0] rsp_value_in;
   logic [31:0]               mag_sum;
   logic [31:0]               mag;
   logic [31:0]               mag_sat;
   logic [spa_pkg::OUT_W-1:0] mag_ext;

   assign mag_sum = {1'b0, poly_in.y} + (32'd1 << (SH - 1));
   assign mag     = mag_sum >> SH;
   assign mag_sat = (mag > MAG_LIM) ? MAG_LIM : mag;
   assign mag_ext = {1'b0, mag_sat[spa_pkg::OUT_W-2:0]};

   assign rsp_value_in = poly_in.negate ? ({spa_pkg::OUT_W{1'b0}} - mag_ext) : mag_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= poly_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine_value = rsp_value_ff;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sine_poly_approx. A short table of directed angles
// (zero, field extremes, multiples of pi/2, rounding boundaries of k) is
// followed by random angles: full range, small angles and angles close to
// multiples of pi/2. Each request transfer pushes the predicted sine onto a
// queue; every strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ANGLE_W      = spa_pkg::ANGLE_W;
   localparam int OUT_W        = spa_pkg::OUT_W;
   localparam int PROD_SH      = spa_pkg::PROD_SH;
   localparam int MAG_SAT_MAX  = spa_pkg::MAG_SAT_MAX;
   localparam int PIPE_LAT     = spa_pkg::PIPE_LAT;
   localparam int ANG_FB       = spa_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int OUT_FB       = spa_pkg::OUT_FRAC_BITS_DEF;
   localparam int N_RANDOM     = 1250;
   localparam int TAIL_NO_IDLE = 150;
   localparam int STALL_LIMIT  = 200;

   typedef longint unsigned u64_type;

   localparam u64_type INV_PI = spa_pkg::INV_PI_Q32;
   localparam longint  PI_Q   = spa_pkg::PI_Q32;
   localparam longint  COEF_A = spa_pkg::COEF_A_Q30;
   localparam longint  COEF_B = -longint'(spa_pkg::COEF_B_MAG_Q30);
   localparam longint  COEF_C = spa_pkg::COEF_C_Q30;

   typedef struct {
      logic [ANGLE_W-1:0] angle;
      bit                 typed;
      logic [OUT_W-1:0]   sine_value;
   } angle_row_type;

   typedef struct {
      logic [ANGLE_W-1:0] angle;
      logic [OUT_W-1:0]   sine_value;
   } sine_exp_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [ANGLE_W-1:0] req_angle;
   logic               rsp_valid;
   logic [OUT_W-1:0]   rsp_sine_value;

   angle_row_type angle_q[$];
   sine_exp_type  sine_exp_q[$];
   int            err_cnt = 0;
   int            stall_cnt;

   sine_poly_approx #(
      .ANGLE_FRAC_BITS(ANG_FB),
      .OUT_FRAC_BITS  (OUT_FB)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_sine_value(rsp_sine_value)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // shift right, rounding half away from zero
   function automatic longint rnd_shr(longint v, int sh);
      u64_type half;
      u64_type mag;
      half = u64_type'(1) << (sh - 1);
      if (v < 0) begin
         mag = u64_type'(-v);
         return -longint'((mag + half) >> sh);
      end
      return longint'((u64_type'(v) + half) >> sh);
   endfunction

   function automatic logic [OUT_W-1:0] sine_predict(logic [ANGLE_W-1:0] angle);
      longint           ang, k, r, x2, p, q, y, mag;
      u64_type          ang_mag, kmag, m, m30;
      bit               ang_neg, r_neg, negate;
      logic [OUT_W-1:0] res;
      ang     = longint'($signed(angle));
      ang_neg = ang < 0;
      ang_mag = ang_neg ? u64_type'(-ang) : u64_type'(ang);
      kmag    = (ang_mag * INV_PI + (u64_type'(1) << (ANG_FB + 31)))
                >> (ANG_FB + 32);
      k       = ang_neg ? -longint'(kmag) : longint'(kmag);
      r       = ang * (longint'(1) << (32 - ANG_FB)) - k * PI_Q;
      r_neg   = r < 0;
      m       = r_neg ? u64_type'(-r) : u64_type'(r);
      m30     = (m + 2) >> 2;
      x2      = rnd_shr(longint'(m30 * m30), PROD_SH);
      p       = COEF_B + rnd_shr(COEF_A * x2, PROD_SH);
      q       = COEF_C + rnd_shr(p * x2, PROD_SH);
      y       = rnd_shr(q * longint'(m30), PROD_SH);
      mag     = rnd_shr(y, PROD_SH - OUT_FB);
      if (mag < 0) mag = 0;
      if (mag > (longint'(1) << OUT_FB)) mag = longint'(1) << OUT_FB;
      if (mag > MAG_SAT_MAX) mag = MAG_SAT_MAX;
      negate = r_neg != kmag[0];
      res    = mag[OUT_W-1:0];
      if (negate) res = -res;
      return res;
   endfunction

   function automatic logic [ANGLE_W-1:0] rand_angle();
      longint a;
      case ($urandom_range(0, 9))
         0, 1, 2: a = longint'($signed($urandom()));
         3, 4, 5: a = longint'($urandom_range(0, 1647098)) - 823549;
         default: begin
            // close to a multiple of pi/2
            a = ((longint'($urandom_range(0, 20000)) * PI_Q) >> (17 + 16 - ANG_FB))
                + longint'($urandom_range(0, 32)) - 16;
            if ($urandom_range(0, 1) == 1) a = -a;
         end
      endcase
      return a[ANGLE_W-1:0];
   endfunction

   task automatic add_angle(logic [ANGLE_W-1:0] a, bit typed = 1'b0,
                            logic [OUT_W-1:0] v = '0);
      angle_q.push_back('{angle: a, typed: typed, sine_value: v});
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      err_cnt++;
   endtask

   always @(posedge clock) begin
      sine_exp_type e;
      if (!reset && rsp_valid !== 1'b0) begin
         if (sine_exp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d",
                                      $signed(rsp_sine_value)));
         end else begin
            e = sine_exp_q.pop_front();
            if (rsp_valid !== 1'b1 || rsp_sine_value !== e.sine_value)
               report_mismatch($sformatf("angle %h: sine_value exp %0d got %0d",
                                         e.angle, $signed(e.sine_value),
                                         $signed(rsp_sine_value)));
         end
      end
   end

   initial begin
      stall_cnt = 0;
      while (stall_cnt < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) stall_cnt = 0;
         else stall_cnt++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int idx;
      int gap;
      int n_dir;
      bit drained;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_angle <= '0;

      add_angle(32'd0, 1'b1, 18'd0);
      add_angle(32'd1);
      add_angle(-32'sd1);
      add_angle(32'h7FFF_FFFF);
      add_angle(32'h8000_0000);
      add_angle(32'd102944);
      add_angle(-32'sd102944);
      add_angle(32'd102943);
      add_angle(32'd205887);
      add_angle(-32'sd205887);
      add_angle(32'd308831);
      add_angle(32'd411775);
      add_angle(32'd20691685);
      add_angle(32'd20691686);
      add_angle(-32'sd20691686);
      add_angle(32'h5555_5555);
      add_angle(32'hAAAA_AAAA);
      add_angle(32'd65536);
      add_angle(-32'sd65536);
      n_dir = angle_q.size();
      repeat (N_RANDOM) add_angle(rand_angle());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idx     = 0;
      gap     = 0;
      drained = 1'b0;
      while (idx < angle_q.size()) begin
         @(posedge clock);
         if (start && !busy) begin
            sine_exp_q.push_back('{angle: angle_q[idx].angle,
                                   sine_value: angle_q[idx].typed ?
                                      angle_q[idx].sine_value :
                                      sine_predict(angle_q[idx].angle)});
            idx++;
            if ($urandom_range(0, 3) == 0 && idx < angle_q.size() - TAIL_NO_IDLE)
               gap = $urandom_range(1, 4);
         end
         if (idx == n_dir && !drained) begin
            // hold off until the directed results are all back
            start <= 1'b0;
            while (sine_exp_q.size() != 0) @(posedge clock);
            drained = 1'b1;
         end else if (idx >= angle_q.size()) begin
            start <= 1'b0;
         end else if (gap > 0) begin
            start <= 1'b0;
            gap--;
         end else begin
            start     <= 1'b1;
            req_angle <= angle_q[idx].angle;
         end
      end

      while (sine_exp_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/spa_pkg.sv
src/spa_reduce.sv
src/spa_poly.sv
src/spa_finish.sv
src/sine_poly_approx.sv
sim/tb_top.sv
